/* src/hall_sensor_travel_linearizer_top_defines.svh */
// ---------------------------------------------------------------------------
// hall_sensor_travel_linearizer_top_defines.svh
// Assertion macros for the hall sensor travel linearizer checkers.
// ---------------------------------------------------------------------------
`ifndef HALL_SENSOR_TRAVEL_LINEARIZER_TOP_DEFINES_SVH
`define HALL_SENSOR_TRAVEL_LINEARIZER_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset
`define HTL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset
`define HTL_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* src/htl_pkg.sv */
// ---------------------------------------------------------------------------
// htl_pkg
// Shared widths, register indexes, status codes and cell token types.
// ---------------------------------------------------------------------------
package htl_pkg;

  localparam int ADC_LIMIT_DEF = 4096;

  localparam int SAMPLE_W = 12;
  localparam int DMAG_W   = 13;              // |sample - base| magnitude
  localparam int NUM_W    = 56;              // |a| * 2^24 magnitude
  localparam int ROOT_W   = 19;              // integer cube root bits
  localparam int RAD_W    = 3 * ROOT_W;      // radicand padded to whole digits
  localparam int CREM_W   = 45;              // cube root partial remainder
  localparam int YSQ_W    = 2 * ROOT_W;      // square of partial root
  localparam int POS_W    = 21;              // signed Q.8 position
  localparam int PROD_W   = 29;              // position times scale times ten

  localparam int DIV_CELLS  = NUM_W;
  localparam int CBRT_CELLS = ROOT_W;
  localparam int LATENCY    = DIV_CELLS + CBRT_CELLS + 3;

  // Register indexes
  localparam logic [2:0] REG_CURVE_A    = 3'd0;
  localparam logic [2:0] REG_CURVE_B    = 3'd1;
  localparam logic [2:0] REG_BASE       = 3'd2;
  localparam logic [2:0] REG_MIN_TRAVEL = 3'd3;
  localparam logic [2:0] REG_SCALE      = 3'd4;
  localparam logic [2:0] REG_MAX_TRAVEL = 3'd5;

  // Clamp status codes
  localparam logic [1:0] CLAMP_NONE = 2'd0;
  localparam logic [1:0] CLAMP_LOW  = 2'd1;
  localparam logic [1:0] CLAMP_HIGH = 2'd2;

  typedef struct packed {
    logic              valid;
    logic              neg;
    logic              zero;
    logic [DMAG_W-1:0] dmag;
    logic [DMAG_W-1:0] rem;
    logic [NUM_W-1:0]  num;   // dividend bits shift out, quotient bits shift in
  } div_tok_t;

  typedef struct packed {
    logic              valid;
    logic              neg;
    logic              zero;
    logic [RAD_W-1:0]  rad;
    logic [CREM_W-1:0] rem;
    logic [ROOT_W-1:0] y;
    logic [YSQ_W-1:0]  ysq;
  } cbrt_tok_t;

endpackage

/* src/htl_div_cell.sv */
// ---------------------------------------------------------------------------
// htl_div_cell
// One restoring division step: retires one quotient bit per cell.
// ---------------------------------------------------------------------------
module htl_div_cell (
  input  logic              clk,
  input  logic              rst,
  input  htl_pkg::div_tok_t tok_in,
  output htl_pkg::div_tok_t tok_out
);
  import htl_pkg::*;

  logic [DMAG_W:0] trial;
  logic [DMAG_W:0] diff;
  logic            ge;
  div_tok_t        tok_next;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    trial    = {tok_in.rem, tok_in.num[NUM_W-1]};
    diff     = trial - {1'b0, tok_in.dmag};
    ge       = (trial >= {1'b0, tok_in.dmag});
    tok_next = tok_in;
    tok_next.rem = ge ? diff[DMAG_W-1:0] : trial[DMAG_W-1:0];
    tok_next.num = {tok_in.num[NUM_W-2:0], ge};
  end

  // Hand the transaction to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

/* src/htl_cbrt_cell.sv */
// ---------------------------------------------------------------------------
// htl_cbrt_cell
// One digit-by-digit cube root step: retires one root bit per cell.
// ---------------------------------------------------------------------------
module htl_cbrt_cell (
  input  logic               clk,
  input  logic               rst,
  input  htl_pkg::cbrt_tok_t tok_in,
  output htl_pkg::cbrt_tok_t tok_out
);
  import htl_pkg::*;

  logic [CREM_W-1:0] cur;
  logic [CREM_W-1:0] step;
  logic              ge;
  cbrt_tok_t         tok_next;

  // Bring down three radicand bits; (2y+1)^3 - (2y)^3 = 12y^2 + 6y + 1
  always_comb begin
    cur  = {tok_in.rem[CREM_W-4:0], tok_in.rad[RAD_W-1 -: 3]};
    step = (CREM_W'(tok_in.ysq) << 3) + (CREM_W'(tok_in.ysq) << 2)
         + (CREM_W'(tok_in.y) << 2) + (CREM_W'(tok_in.y) << 1) + CREM_W'(1);
    ge   = (cur >= step);
    tok_next     = tok_in;
    tok_next.rad = tok_in.rad << 3;
    tok_next.rem = ge ? (cur - step) : cur;
    tok_next.y   = {tok_in.y[ROOT_W-2:0], ge};
    tok_next.ysq = ge ? ((tok_in.ysq << 2) + (YSQ_W'(tok_in.y) << 2) + YSQ_W'(1))
                      : (tok_in.ysq << 2);
  end

  // Hand the transaction to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

/* src/htl_post.sv */
// ---------------------------------------------------------------------------
// htl_post
// Offset, scaling and clamping of the root into the travel code.
// ---------------------------------------------------------------------------
module htl_post (
  input  logic               clk,
  input  logic               rst,
  input  htl_pkg::cbrt_tok_t tok_in,
  input  logic signed [15:0] curve_b_q8,
  input  logic [11:0]        min_travel_q8,
  input  logic [4:0]         table_scale,
  input  logic [7:0]         max_travel_dmm,
  output logic               done,
  output logic [7:0]         travel_code,
  output logic [1:0]         clamp_status
);
  import htl_pkg::*;

  function automatic logic [7:0] sat8(input logic [20:0] v);
    sat8 = (v > 21'd255) ? 8'hFF : v[7:0];
  endfunction

  logic signed [POS_W-1:0] root_s;
  logic signed [POS_W-1:0] pos;
  logic [8:0]              scale10;
  logic                    a_valid;
  logic                    a_low;
  logic                    a_zero;
  logic [PROD_W-1:0]       a_prod;
  logic [20:0]             code;
  logic [20:0]             min_prod;
  logic [12:0]             max_code;
  logic [7:0]              code_next;
  logic [1:0]              status_next;

  // Signed root minus offset, then scale by ten times the table scale
  always_comb begin
    root_s  = tok_in.neg ? -$signed({2'b00, tok_in.y}) : $signed({2'b00, tok_in.y});
    pos     = root_s - POS_W'(curve_b_q8);
    scale10 = {1'b0, table_scale, 3'b000} + {3'b000, table_scale, 1'b0};
  end

  always_ff @(posedge clk) begin
    a_low  <= (pos < $signed({9'd0, min_travel_q8}));
    a_zero <= tok_in.zero;
    a_prod <= PROD_W'(pos[POS_W-2:0]) * PROD_W'(scale10);
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= tok_in.valid;
    end
  end

  // Clamp against the minimum travel and the maximum code
  always_comb begin
    code     = a_prod[PROD_W-1:8];
    min_prod = 21'(min_travel_q8) * 21'(scale10);
    max_code = 13'(max_travel_dmm) * 13'(table_scale);
    priority if (a_zero) begin
      code_next   = sat8(21'(max_code));
      status_next = CLAMP_HIGH;
    end else if (a_low) begin
      code_next   = sat8(21'(min_prod[20:8]));
      status_next = CLAMP_LOW;
    end else if (code > 21'(max_code)) begin
      code_next   = sat8(21'(max_code));
      status_next = CLAMP_HIGH;
    end else begin
      code_next   = sat8(code);
      status_next = CLAMP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    travel_code  <= code_next;
    clamp_status <= status_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= a_valid;
    end
  end

endmodule

/* src/hall_sensor_travel_linearizer_top.sv */
// ---------------------------------------------------------------------------
// hall_sensor_travel_linearizer_top
// Hall sensor sample to key-travel code through an inverse-cube curve.
// ---------------------------------------------------------------------------
// One sample may be started on every clock (busy stays low) and its result
// appears, marked by done for one cycle, after one input stage, 56 division
// cells (one quotient bit each), 19 cube root cells (one root bit each) and
// two stages of offset, scaling and clamping. The result must be taken in its
// done cycle; it is not held. Registers are to be written only while no
// sample is in flight.
// ---------------------------------------------------------------------------
module hall_sensor_travel_linearizer_top #(
  parameter int ADC_LIMIT = htl_pkg::ADC_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [11:0] adc_sample,
  output logic        done,
  output logic [7:0]  travel_code,
  output logic [1:0]  clamp_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import htl_pkg::*;

  logic signed [31:0] curve_a;
  logic signed [15:0] curve_b_q8;
  logic signed [12:0] rest_level;
  logic [11:0]        min_travel_q8;
  logic [4:0]         table_scale;
  logic [7:0]         max_travel_dmm;
  logic [2:0]         reg_idx;
  logic               wr_en;

  logic [SAMPLE_W-1:0] sample;
  logic signed [13:0]  d;
  logic [DMAG_W-1:0]   dmag;
  logic [31:0]         amag;
  div_tok_t            in_tok;
  div_tok_t            div_pipe [DIV_CELLS+1];
  cbrt_tok_t           cbrt_pipe [CBRT_CELLS+1];

  assign busy    = 1'b0;
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      curve_a        <= '0;
      curve_b_q8     <= '0;
      rest_level     <= '0;
      min_travel_q8  <= '0;
      table_scale    <= 5'd1;
      max_travel_dmm <= 8'd40;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CURVE_A:    curve_a        <= pwdata;
        REG_CURVE_B:    curve_b_q8     <= pwdata[15:0];
        REG_BASE:       rest_level     <= pwdata[12:0];
        REG_MIN_TRAVEL: min_travel_q8  <= pwdata[11:0];
        REG_SCALE:      table_scale    <= pwdata[4:0];
        REG_MAX_TRAVEL: max_travel_dmm <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CURVE_A:    prdata = curve_a;
      REG_CURVE_B:    prdata = {16'd0, curve_b_q8};
      REG_BASE:       prdata = {19'd0, rest_level};
      REG_MIN_TRAVEL: prdata = {20'd0, min_travel_q8};
      REG_SCALE:      prdata = {27'd0, table_scale};
      REG_MAX_TRAVEL: prdata = {24'd0, max_travel_dmm};
      default:        prdata = '0;
    endcase
  end

  // Saturate the sample, form the divisor and dividend magnitudes
  always_comb begin
    sample = (32'(adc_sample) >= 32'(ADC_LIMIT)) ? SAMPLE_W'(ADC_LIMIT - 1) : adc_sample;
    d      = $signed({2'b00, sample}) - $signed({rest_level[12], rest_level});
    dmag   = d[13] ? DMAG_W'(-d) : DMAG_W'(d);
    amag   = curve_a[31] ? 32'(-curve_a) : 32'(curve_a);
    in_tok.valid = start;
    in_tok.neg   = curve_a[31] ^ d[13];
    in_tok.zero  = (d == 14'sd0);
    in_tok.dmag  = dmag;
    in_tok.rem   = '0;
    in_tok.num   = {amag, 24'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_pipe[0] <= '0;
    end else begin
      div_pipe[0] <= in_tok;
    end
  end

  // Division chain
  for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
    htl_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (div_pipe[k]),
      .tok_out (div_pipe[k+1])
    );
  end

  // Quotient magnitude becomes the cube root radicand
  always_comb begin
    cbrt_pipe[0].valid = div_pipe[DIV_CELLS].valid;
    cbrt_pipe[0].neg   = div_pipe[DIV_CELLS].neg;
    cbrt_pipe[0].zero  = div_pipe[DIV_CELLS].zero;
    cbrt_pipe[0].rad   = RAD_W'(div_pipe[DIV_CELLS].num);
    cbrt_pipe[0].rem   = '0;
    cbrt_pipe[0].y     = '0;
    cbrt_pipe[0].ysq   = '0;
  end

  // Cube root chain
  for (genvar k = 0; k < CBRT_CELLS; k++) begin : g_cbrt
    htl_cbrt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (cbrt_pipe[k]),
      .tok_out (cbrt_pipe[k+1])
    );
  end

  htl_post u_post (
    .clk            (clk),
    .rst            (rst),
    .tok_in         (cbrt_pipe[CBRT_CELLS]),
    .curve_b_q8     (curve_b_q8),
    .min_travel_q8  (min_travel_q8),
    .table_scale    (table_scale),
    .max_travel_dmm (max_travel_dmm),
    .done           (done),
    .travel_code    (travel_code),
    .clamp_status   (clamp_status)
  );

endmodule

/* src/htl_checker.sv */
// ---------------------------------------------------------------------------
// htl_checker
// Port-level checks of the linearizer, bound to the top level.
// ---------------------------------------------------------------------------
`include "hall_sensor_travel_linearizer_top_defines.svh"

module htl_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [1:0] clamp_status
);
  import htl_pkg::*;

  `HTL_NEVER(a_never_busy, busy, "linearizer raised busy")
  `HTL_NEVER(a_status_code, done && clamp_status[1] && clamp_status[0], "bad clamp status")
  `HTL_ASSERT(a_done_follows, (start && !busy) |-> ##LATENCY done, "result missing")
  `HTL_ASSERT(a_done_caused, done |-> $past(start && !busy, LATENCY), "spurious result")

endmodule

bind hall_sensor_travel_linearizer_top htl_checker u_htl_checker (.*);
